/* rtl/core/rbsi_pkg.sv */
// Shared constants for the ray against box slab test.
package rbsi_pkg;

  localparam int DATA_W = 32;
  localparam int LANES  = 6;   // two slab bounds per axis
  localparam int AXES   = 3;

  localparam logic signed [DATA_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] T_MIN = 32'sh8000_0000;

  // Register map, index = paddr / 4
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

endpackage

/* rtl/core/ray_box_slab_intersection.sv */
// Ray against axis-aligned box slab test, pipelined one request per cycle.
//
// Box corners sit in six APB registers (min x/y/z at 0x00..0x08, max x/y/z
// at 0x0C..0x14); the user must see they are written only while the pipeline
// is empty, which the block does not check. A request on the input channel
// carries a ray origin and direction in signed fixed point with FRAC_BITS
// fraction bits. Each axis yields two slab distances (bound - origin) / dir,
// truncated toward zero and saturated to 32 bits; a zero direction gives an
// open slab or a forced miss.
//
// The result gives hit, behind and a distance (entry distance on a hit, exit
// distance otherwise). Throughput: one request per cycle unless stalled. The
// pipe holds one operand stage, a divider load stage, 32 restoring divider
// stages that settle one quotient bit each for all six slab bounds in
// parallel, two compare stages and the output register. The pipe advances
// when the output register is empty or being taken, so a stalled receiver
// holds every stage in place and in_ready drops until the result leaves.
// Reset clears all valid bits and the box registers to zero.
module ray_box_slab_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [4:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // ray requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rbsi_pkg::DATA_W-1:0]   origin_x,
  input  logic signed [rbsi_pkg::DATA_W-1:0]   origin_y,
  input  logic signed [rbsi_pkg::DATA_W-1:0]   origin_z,
  input  logic signed [rbsi_pkg::DATA_W-1:0]   dir_x,
  input  logic signed [rbsi_pkg::DATA_W-1:0]   dir_y,
  input  logic signed [rbsi_pkg::DATA_W-1:0]   dir_z,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic                                 behind,
  output logic signed [rbsi_pkg::DATA_W-1:0]   hit_distance
);
  import rbsi_pkg::*;

  localparam int W     = DATA_W;
  localparam int QBITS = W;        // quotient bits kept before saturation
  localparam int DSTG  = QBITS;    // divider iterations

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [W-1:0] box_r [0:LANES-1];
  logic [2:0]          reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) box_r[i] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_MIN_X: box_r[0] <= pwdata;
        REG_MIN_Y: box_r[1] <= pwdata;
        REG_MIN_Z: box_r[2] <= pwdata;
        REG_MAX_X: box_r[3] <= pwdata;
        REG_MAX_Y: box_r[4] <= pwdata;
        REG_MAX_Z: box_r[5] <= pwdata;
        default: ;  // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_X: prdata = box_r[0];
      REG_MIN_Y: prdata = box_r[1];
      REG_MIN_Z: prdata = box_r[2];
      REG_MAX_X: prdata = box_r[3];
      REG_MAX_Y: prdata = box_r[4];
      REG_MAX_Z: prdata = box_r[5];
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control: everything moves together when the output frees up
  // ---------------------------------------------------------------------
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  logic signed [W-1:0] org_in [0:AXES-1];
  logic signed [W-1:0] dir_in [0:AXES-1];

  assign org_in[0] = origin_x;
  assign org_in[1] = origin_y;
  assign org_in[2] = origin_z;
  assign dir_in[0] = dir_x;
  assign dir_in[1] = dir_y;
  assign dir_in[2] = dir_z;

  // ---------------------------------------------------------------------
  // Operand stage: differences, magnitudes, signs, zero-direction cases
  // Lane 2*axis is the lower bound, lane 2*axis+1 the upper bound.
  // ---------------------------------------------------------------------
  logic         a_vld;
  logic [W-1:0] a_mag [0:LANES-1];
  logic [W-1:0] a_dv  [0:LANES-1];
  logic         a_neg [0:LANES-1];
  logic         a_dz  [0:AXES-1];
  logic         a_blw [0:AXES-1];
  logic         a_abv [0:AXES-1];

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (advance) a_vld <= in_valid;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_opnd
    localparam int AX = l / 2;
    logic signed [W:0] diff;
    logic signed [W:0] dext;
    logic        [W:0] dmag;
    logic        [W:0] nmag;

    always_comb begin
      diff = {box_r[AX + AXES*(l%2)][W-1], box_r[AX + AXES*(l%2)]}
           - {org_in[AX][W-1], org_in[AX]};
      dext = {dir_in[AX][W-1], dir_in[AX]};
      nmag = diff[W] ? -diff : diff;
      dmag = dext[W] ? -dext : dext;
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        a_mag[l] <= nmag[W-1:0];
        a_dv[l]  <= dmag[W-1:0];
        a_neg[l] <= diff[W] ^ dext[W];
      end
    end
  end

  for (genvar ax = 0; ax < AXES; ax++) begin : g_zero
    always_ff @(posedge clk) begin
      if (advance) begin
        a_dz[ax]  <= (dir_in[ax] == '0);
        a_blw[ax] <= (org_in[ax] < box_r[ax]);
        a_abv[ax] <= (org_in[ax] > box_r[ax + AXES]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Restoring divider: stage 0 loads, each later stage settles one bit
  // ---------------------------------------------------------------------
  logic         d_vld [0:DSTG];
  logic [W-1:0] d_rem [0:DSTG][0:LANES-1];
  logic [W-1:0] d_low [0:DSTG][0:LANES-1];
  logic [W-1:0] d_q   [0:DSTG][0:LANES-1];
  logic [W-1:0] d_dv  [0:DSTG][0:LANES-1];
  logic         d_ovf [0:DSTG][0:LANES-1];
  logic         d_neg [0:DSTG][0:LANES-1];
  logic         d_dz  [0:DSTG][0:AXES-1];
  logic         d_blw [0:DSTG][0:AXES-1];
  logic         d_abv [0:DSTG][0:AXES-1];

  always_ff @(posedge clk) begin
    if (rst) d_vld[0] <= 1'b0;
    else if (advance) d_vld[0] <= a_vld;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_load
    logic [W-1:0] rem0;
    // numerator is mag << FRAC_BITS; the part above the quotient bits
    // seeds the remainder, a quotient of 2^32 or more saturates anyway
    assign rem0 = {{(W-FRAC_BITS){1'b0}}, a_mag[l][W-1 -: FRAC_BITS]};

    always_ff @(posedge clk) begin
      if (advance) begin
        d_rem[0][l] <= rem0;
        d_low[0][l] <= {a_mag[l][W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        d_q[0][l]   <= '0;
        d_dv[0][l]  <= a_dv[l];
        d_ovf[0][l] <= (rem0 >= a_dv[l]);
        d_neg[0][l] <= a_neg[l];
      end
    end
  end

  for (genvar ax = 0; ax < AXES; ax++) begin : g_load_ax
    always_ff @(posedge clk) begin
      if (advance) begin
        d_dz[0][ax]  <= a_dz[ax];
        d_blw[0][ax] <= a_blw[ax];
        d_abv[0][ax] <= a_abv[ax];
      end
    end
  end

  for (genvar s = 0; s < DSTG; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) d_vld[s+1] <= 1'b0;
      else if (advance) d_vld[s+1] <= d_vld[s];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [W:0] trial;
      logic [W:0] sub;
      logic       ge;

      always_comb begin
        trial = {d_rem[s][l], d_low[s][l][W-1]};
        sub   = trial - {1'b0, d_dv[s][l]};
        ge    = (trial >= {1'b0, d_dv[s][l]});
      end

      always_ff @(posedge clk) begin
        if (advance) begin
          d_rem[s+1][l] <= ge ? sub[W-1:0] : trial[W-1:0];
          d_low[s+1][l] <= {d_low[s][l][W-2:0], 1'b0};
          d_q[s+1][l]   <= {d_q[s][l][W-2:0], ge};
          d_dv[s+1][l]  <= d_dv[s][l];
          d_ovf[s+1][l] <= d_ovf[s][l];
          d_neg[s+1][l] <= d_neg[s][l];
        end
      end
    end

    for (genvar ax = 0; ax < AXES; ax++) begin : g_ax
      always_ff @(posedge clk) begin
        if (advance) begin
          d_dz[s+1][ax]  <= d_dz[s][ax];
          d_blw[s+1][ax] <= d_blw[s][ax];
          d_abv[s+1][ax] <= d_abv[s][ax];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Slab stage: sign and saturate, apply zero-direction rules, order ends
  // ---------------------------------------------------------------------
  logic signed [W-1:0] t_lane [0:LANES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_sat
    logic [W-1:0] q;
    assign q = d_q[DSTG][l];

    always_comb begin
      if (!d_neg[DSTG][l]) begin
        t_lane[l] = (d_ovf[DSTG][l] || q[W-1]) ? T_MAX : q;
      end else if (d_ovf[DSTG][l] || (q[W-1] && (q[W-2:0] != '0))) begin
        t_lane[l] = T_MIN;
      end else begin
        t_lane[l] = -q;
      end
    end
  end

  logic                f1_vld;
  logic signed [W-1:0] f1_near [0:AXES-1];
  logic signed [W-1:0] f1_far  [0:AXES-1];
  logic                f1_miss;

  always_ff @(posedge clk) begin
    if (rst) f1_vld <= 1'b0;
    else if (advance) f1_vld <= d_vld[DSTG];
  end

  for (genvar ax = 0; ax < AXES; ax++) begin : g_slab
    logic signed [W-1:0] ta;
    logic signed [W-1:0] tb;
    assign ta = t_lane[2*ax];
    assign tb = t_lane[2*ax+1];

    always_ff @(posedge clk) begin
      if (advance) begin
        if (d_dz[DSTG][ax]) begin
          if (d_blw[DSTG][ax]) begin
            f1_near[ax] <= T_MAX;
            f1_far[ax]  <= T_MAX;
          end else if (d_abv[DSTG][ax]) begin
            f1_near[ax] <= T_MIN;
            f1_far[ax]  <= T_MIN;
          end else begin
            f1_near[ax] <= T_MIN;
            f1_far[ax]  <= T_MAX;
          end
        end else if (ta < tb) begin
          f1_near[ax] <= ta;
          f1_far[ax]  <= tb;
        end else begin
          f1_near[ax] <= tb;
          f1_far[ax]  <= ta;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1_miss <= (d_dz[DSTG][0] && (d_blw[DSTG][0] || d_abv[DSTG][0]))
              || (d_dz[DSTG][1] && (d_blw[DSTG][1] || d_abv[DSTG][1]))
              || (d_dz[DSTG][2] && (d_blw[DSTG][2] || d_abv[DSTG][2]));
    end
  end

  // ---------------------------------------------------------------------
  // Reduce: entry is the latest near distance, exit the earliest far one
  // ---------------------------------------------------------------------
  logic                f2_vld;
  logic signed [W-1:0] f2_tmin;
  logic signed [W-1:0] f2_tmax;
  logic                f2_miss;
  logic signed [W-1:0] mx01;
  logic signed [W-1:0] mn01;

  assign mx01 = (f1_near[1] > f1_near[0]) ? f1_near[1] : f1_near[0];
  assign mn01 = (f1_far[1]  < f1_far[0])  ? f1_far[1]  : f1_far[0];

  always_ff @(posedge clk) begin
    if (rst) f2_vld <= 1'b0;
    else if (advance) f2_vld <= f1_vld;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f2_tmin <= (f1_near[2] > mx01) ? f1_near[2] : mx01;
      f2_tmax <= (f1_far[2]  < mn01) ? f1_far[2]  : mn01;
      f2_miss <= f1_miss;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: decide hit and pick the reported distance
  // ---------------------------------------------------------------------
  logic behind_next;
  logic hit_next;

  assign behind_next = f2_tmax[W-1];
  assign hit_next    = !f2_miss && !behind_next && (f2_tmin <= f2_tmax);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= f2_vld;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit          <= hit_next;
      behind       <= behind_next;
      hit_distance <= hit_next ? f2_tmin : f2_tmax;
    end
  end

endmodule
